// ----- sv/tuic_pkg.sv -----
// ----------------------------------------------------------------------------
// tuic_pkg: shared types, constants and functions
// Lane geometry, protocol codes and ones' complement helpers for the
// TCP/UDP internet checksum block.
// ----------------------------------------------------------------------------
package tuic_pkg;

	localparam int LANE_BYTES = 4;
	localparam int DATA_W     = 8 * LANE_BYTES;
	localparam int CNT_W      = 3;
	localparam int LANES      = (LANE_BYTES + 1) / 2;
	// lane words + 5 pseudo-header words + length word
	localparam int NWORDS     = LANES + 6;
	localparam int SUM_W      = 16 + $clog2(NWORDS);

	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	typedef logic [LANES-1:0][15:0] lane_words_t;

	typedef struct packed {
		logic vld;
		logic last;
	} pipe_ctl_t;

	// end-around carry add of two words
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + 16'(s[16]);
	endfunction

	// fold a wide sum back to 16 bits with end-around carry
	function automatic logic [15:0] oc_fold(input logic [SUM_W-1:0] s);
		logic [16:0] x;
		x = 17'(s[15:0]) + 17'(s >> 16);
		return x[15:0] + 16'(x[16]);
	endfunction

endpackage

// ----- sv/tuic_lane.sv -----
// ----------------------------------------------------------------------------
// tuic_lane: one 16-bit word lane
// Masks the two bytes of its word by the item's byte count and registers
// the word for the merge stage.
// ----------------------------------------------------------------------------
module tuic_lane (
	input  logic        clk,
	input  logic        adv,
	input  logic [7:0]  hi_byte,
	input  logic [7:0]  lo_byte,
	input  logic        hi_en,
	input  logic        lo_en,
	output logic [15:0] word_s1
);

	logic [15:0] word;

	// missing bytes count as zero padding
	assign word = {(hi_en ? hi_byte : 8'h00), (lo_en ? lo_byte : 8'h00)};

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1 <= word;
		end
	end

endmodule

// ----- sv/tuic_merge.sv -----
// ----------------------------------------------------------------------------
// tuic_merge: lane merge stage
// Adds the lane words, the pseudo-header words on a TCP or UDP packet's first
// item and the payload length on its last item, then folds to 16 bits.
// ----------------------------------------------------------------------------
module tuic_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  tuic_pkg::pipe_ctl_t   ctl_s1,
	input  tuic_pkg::lane_words_t words_s1,
	input  logic                  pseudo_s1,
	input  logic [31:0]           src_s1,
	input  logic [31:0]           dst_s1,
	input  logic [7:0]            proto_s1,
	input  logic [15:0]           len_s1,
	output tuic_pkg::pipe_ctl_t   ctl_s2,
	output logic [15:0]           part_s2
);
	import tuic_pkg::*;

	logic [SUM_W-1:0] sum;

	always_comb begin
		sum = '0;
		for (int j = 0; j < LANES; j++) begin
			sum = sum + SUM_W'(words_s1[j]);
		end
		if (pseudo_s1) begin
			sum = sum + SUM_W'(src_s1[31:16]) + SUM_W'(src_s1[15:0])
				+ SUM_W'(dst_s1[31:16]) + SUM_W'(dst_s1[15:0]) + SUM_W'(proto_s1);
		end
		if (ctl_s1.last) begin
			sum = sum + SUM_W'(len_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			part_s2 <= oc_fold(sum);
		end
	end

endmodule

// ----- sv/tcp_udp_internet_checksum.sv -----
// ----------------------------------------------------------------------------
// tcp_udp_internet_checksum: streaming TCP/UDP internet checksum
// Sums packet payload in ones' complement, adds the pseudo-header for TCP
// and UDP, and emits the complemented checksum on the packet's last item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item carries LANE_BYTES payload
//   bytes, first wire byte in the top byte, plus byte_count and last. The
//   addresses and protocol are only looked at on a packet's first item;
//   protocol 6 or 17 adds the pseudo-header and the payload length.
//   Output channel (out_valid / out_stall): one checksum per packet, shown
//   after the item marked last.
// Throughput: one item per cycle while no checksum waits under out_stall, any
//   packet length, packets back to back. Each lane handles one 16-bit word;
//   the merge stage adds lane words, pseudo-header and length in one tree,
//   and the accumulator adds one folded word per cycle.
// Path: the last item passes stage 1, then merge, then the output register.
// Stall: the three stages advance together; while a checksum sits in the
//   output register under out_stall, in_stall is raised and nothing moves.
// Reset: arst_n clears all valid bits, the running sum and the length; the
//   next item is taken as the first of a packet.
// ----------------------------------------------------------------------------
module tcp_udp_internet_checksum (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [tuic_pkg::DATA_W-1:0]  data_bytes,
	input  logic [tuic_pkg::CNT_W-1:0]   byte_count,
	input  logic                         last,
	input  logic [31:0]                  src_addr,
	input  logic [31:0]                  dst_addr,
	input  logic [7:0]                   protocol,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [15:0]                  checksum
);
	import tuic_pkg::*;

	// pipeline advance: only a stalled, full output register holds things up
	logic adv;
	logic accept;

	// packet tracking at the input
	logic             start_q;
	logic             en_q;
	logic [15:0]      len_q;
	logic [CNT_W-1:0] cnt_sat;
	logic             proto_hit;
	logic             en_now;
	logic [15:0]      len_now;

	// stage 1
	pipe_ctl_t   ctl_s1;
	lane_words_t words_s1;
	logic        pseudo_s1;
	logic [31:0] src_s1;
	logic [31:0] dst_s1;
	logic [7:0]  proto_s1;
	logic [15:0] len_s1;

	// stage 2
	pipe_ctl_t   ctl_s2;
	logic [15:0] part_s2;

	// accumulator and output
	logic [15:0] acc_q;
	logic [15:0] acc_nxt;
	logic        out_vld_q;
	logic [15:0] checksum_q;

	assign adv      = !(out_vld_q && out_stall);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;

	// counts above the lane width saturate
	assign cnt_sat = (32'(byte_count) > 32'(LANE_BYTES)) ? CNT_W'(LANE_BYTES) : byte_count;

	assign proto_hit = (protocol == PROTO_TCP) || (protocol == PROTO_UDP);
	assign en_now    = start_q ? proto_hit : en_q;
	// length stays zero while the pseudo-header is off
	assign len_now   = en_now ? (len_q + 16'(cnt_sat)) : len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			en_q    <= 1'b0;
			len_q   <= '0;
		end else if (accept) begin
			if (last) begin
				start_q <= 1'b1;
				en_q    <= 1'b0;
				len_q   <= '0;
			end else begin
				start_q <= 1'b0;
				en_q    <= en_now;
				len_q   <= len_now;
			end
		end
	end

	// word lanes: byte 2j is the high byte, byte 2j+1 the low byte
	for (genvar j = 0; j < LANES; j++) begin : g_lane
		logic [7:0] hi_b;
		logic [7:0] lo_b;
		logic       hi_e;
		logic       lo_e;

		assign hi_b = data_bytes[(LANE_BYTES - 1 - 2*j)*8 +: 8];
		assign hi_e = 32'(cnt_sat) > 32'(2*j);

		if (2*j + 1 < LANE_BYTES) begin : g_lo
			assign lo_b = data_bytes[(LANE_BYTES - 2 - 2*j)*8 +: 8];
			assign lo_e = 32'(cnt_sat) > 32'(2*j + 1);
		end else begin : g_pad
			assign lo_b = 8'h00;
			assign lo_e = 1'b0;
		end

		tuic_lane u_lane (
			.clk     (clk),
			.adv     (adv),
			.hi_byte (hi_b),
			.lo_byte (lo_b),
			.hi_en   (hi_e),
			.lo_en   (lo_e),
			.word_s1 (words_s1[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.vld  <= in_valid;
			ctl_s1.last <= last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pseudo_s1 <= start_q && proto_hit;
			src_s1    <= src_addr;
			dst_s1    <= dst_addr;
			proto_s1  <= protocol;
			len_s1    <= len_now;
		end
	end

	tuic_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.ctl_s1    (ctl_s1),
		.words_s1  (words_s1),
		.pseudo_s1 (pseudo_s1),
		.src_s1    (src_s1),
		.dst_s1    (dst_s1),
		.proto_s1  (proto_s1),
		.len_s1    (len_s1),
		.ctl_s2    (ctl_s2),
		.part_s2   (part_s2)
	);

	// accumulator: one folded word per item
	assign acc_nxt = oc_add(acc_q, part_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= ctl_s2.vld && ctl_s2.last;
			if (ctl_s2.vld) begin
				acc_q <= ctl_s2.last ? 16'h0000 : acc_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s2.vld && ctl_s2.last) begin
			checksum_q <= ~acc_nxt;
		end
	end

	assign out_valid = out_vld_q;
	assign checksum  = checksum_q;

	// packet end returns the input tracker to a fresh start
	a_start_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> start_q && !en_q && (len_q == 16'h0000))
		else $error("tracker not cleared after last item");

	// length only grows while the pseudo-header is enabled
	a_len_needs_en: assert property (@(posedge clk) disable iff (!arst_n)
		!en_q |-> (len_q == 16'h0000))
		else $error("length counted with pseudo-header off");

	// accumulator is empty once a packet has been closed out
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctl_s2.vld && ctl_s2.last |=> (acc_q == 16'h0000) && out_valid)
		else $error("accumulator not cleared at packet end");

	// a checksum only appears behind a last item in the merge stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(ctl_s2.vld && ctl_s2.last))
		else $error("checksum without a last item");

endmodule

// ----- dv/tb_tcp_udp_internet_checksum.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tcp_udp_internet_checksum: self-checking bench for the streaming checksum
// Drives packets (directed corners, then random packets under four idle/stall
// mixes) and compares every emitted checksum against an independent ones'
// complement predictor.
// ----------------------------------------------------------------------------
module tb_tcp_udp_internet_checksum;

	import tuic_pkg::*;

	localparam int CLK_PERIOD = 10;

	// ------------------------------------------------------------------------
	// Checksum predictor and expected-result store
	// ------------------------------------------------------------------------
	class cksum_scoreboard;
		logic [15:0] acc       = '0;   // folded sum of the packet so far
		logic [15:0] len_mod   = '0;   // payload bytes, mod 2^16
		bit          pseudo_on = 1'b0; // TCP/UDP pseudo-header in effect
		bit          first     = 1'b1; // next item opens a packet
		logic [15:0] cksum_q[$];
		int          errors    = 0;

		task flag_mismatch(string msg);
			errors++;
			$display("ERROR @%0t: %s", $realtime, msg);
		endtask

		// end-around carry add
		function logic [15:0] add1c(logic [15:0] a, logic [15:0] b);
			logic [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[15:0] + {15'd0, s[16]};
		endfunction

		function void note_input(logic [DATA_W-1:0] data, logic [CNT_W-1:0] cnt,
				logic lst, logic [31:0] src, logic [31:0] dst, logic [7:0] proto);
			int n;
			int i;
			logic [7:0] b;
			n = (cnt > LANE_BYTES) ? LANE_BYTES : int'(cnt);
			if (first) begin
				pseudo_on = (proto == PROTO_TCP) || (proto == PROTO_UDP);
				if (pseudo_on) begin
					acc = add1c(acc, src[31:16]);
					acc = add1c(acc, src[15:0]);
					acc = add1c(acc, dst[31:16]);
					acc = add1c(acc, dst[15:0]);
					acc = add1c(acc, {8'h00, proto});
				end
				first = 1'b0;
			end
			// even byte positions are word highs, odd ones lows, per item
			for (i = 0; i < n; i++) begin
				b = data[(LANE_BYTES - 1 - i) * 8 +: 8];
				acc = add1c(acc, i[0] ? {8'h00, b} : {b, 8'h00});
			end
			if (pseudo_on)
				len_mod = len_mod + 16'(n);
			if (lst) begin
				acc = add1c(acc, len_mod);
				cksum_q.push_back(~acc);
				acc       = '0;
				len_mod   = '0;
				pseudo_on = 1'b0;
				first     = 1'b1;
			end
		endfunction

		task check_result(logic [15:0] got);
			logic [15:0] want;
			if (cksum_q.size() == 0) begin
				flag_mismatch($sformatf("checksum %04h with none expected", got));
				return;
			end
			want = cksum_q.pop_front();
			if (got !== want)
				flag_mismatch($sformatf("checksum got %04h want %04h", got, want));
		endtask
	endclass

	// ------------------------------------------------------------------------
	// DUT and stimulus signals
	// ------------------------------------------------------------------------
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [DATA_W-1:0] data_bytes = '0;
	logic [CNT_W-1:0]  byte_count = '0;
	logic              last       = 1'b0;
	logic [31:0]       src_addr   = '0;
	logic [31:0]       dst_addr   = '0;
	logic [7:0]        protocol   = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic [15:0]       checksum;

	int gap_pct   = 0;  // chance per cycle that the sender holds off
	int stall_pct = 0;  // chance per cycle that the receiver stalls

	cksum_scoreboard sb = new();

	tcp_udp_internet_checksum DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_bytes (data_bytes),
		.byte_count (byte_count),
		.last       (last),
		.src_addr   (src_addr),
		.dst_addr   (dst_addr),
		.protocol   (protocol),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.checksum   (checksum)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// receiver backpressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// output monitor: one checksum taken per unstalled out_valid
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(checksum);
	end

	// ------------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------------
	// Called at a falling edge; returns at the falling edge after acceptance
	// with in_valid still high, so back-to-back items see no bubble.
	task automatic send_item(logic [DATA_W-1:0] data, logic [CNT_W-1:0] cnt, logic lst,
			logic [31:0] src, logic [31:0] dst, logic [7:0] proto);
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		data_bytes <= data;
		byte_count <= cnt;
		last       <= lst;
		src_addr   <= src;
		dst_addr   <= dst;
		protocol   <= proto;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(data, cnt, lst, src, dst, proto);
		@(negedge clk);
	endtask

	// payloads lean toward the all-zero and all-one corners now and then
	function automatic logic [DATA_W-1:0] pick_data();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_proto();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return PROTO_TCP;
		if (r < 7)
			return PROTO_UDP;
		return 8'($urandom_range(0, 255));
	endfunction

	// one random packet; later items carry junk addresses and protocol,
	// which the block must ignore
	task automatic run_random_packet(output int n_items);
		int          len;
		int          k;
		logic [7:0]  proto;
		logic [31:0] src;
		logic [31:0] dst;
		logic [CNT_W-1:0] cnt;
		logic        lst;
		len   = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
		proto = pick_proto();
		src   = $urandom;
		dst   = $urandom;
		for (k = 0; k < len; k++) begin
			lst = (k == len - 1);
			// mostly full items mid-packet; short, empty or oversized sometimes
			if (lst || $urandom_range(0, 9) < 2)
				cnt = CNT_W'($urandom_range(0, 7));
			else
				cnt = CNT_W'(LANE_BYTES);
			if (k == 0)
				send_item(pick_data(), cnt, lst, src, dst, proto);
			else
				send_item(pick_data(), cnt, lst, $urandom, $urandom, 8'($urandom));
		end
		n_items = len;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int ph;
		int sent;
		int n;
		int drain;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners, no idling
		// all-ones everything under TCP
		send_item('1, 3'd4, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, PROTO_TCP);
		// empty sum: no pseudo-header, empty last item
		send_item('0, 3'd0, 1'b1, 32'h0, 32'h0, 8'd0);
		// UDP whose first item is empty, so the length is still zero mid-packet
		send_item(32'hDEAD_BEEF, 3'd0, 1'b0, 32'hC0A8_0001, 32'h0A00_0002, PROTO_UDP);
		send_item(32'h1234_5678, 3'd4, 1'b1, 32'h0, 32'h0, 8'd0);
		// non-pseudo protocol, oversized count saturates, odd tail is padded
		send_item('0, 3'd4, 1'b0, 32'h0102_0304, 32'h0506_0708, 8'hFF);
		send_item(32'hA5A5_A5A5, 3'd7, 1'b0, 32'h0, 32'h0, PROTO_TCP);
		send_item(32'h1234_5678, 3'd3, 1'b1, 32'h0, 32'h0, PROTO_UDP);
		// short items mid-packet restart word alignment; later fields ignored
		send_item(32'hAB00_0000, 3'd1, 1'b0, 32'h8000_0001, 32'h7FFF_FFFE, PROTO_TCP);
		send_item(32'h1122_3344, 3'd3, 1'b0, 32'hFFFF_FFFF, 32'h0, 8'd1);
		send_item(32'h5566_7788, 3'd2, 1'b1, 32'h0, 32'hFFFF_FFFF, PROTO_UDP);
		// single top byte, zero addresses
		send_item(32'h8000_0000, 3'd1, 1'b1, 32'h0, 32'h0, PROTO_UDP);
		// pseudo-header alone with zero length
		send_item(32'hFFFF_FFFF, 3'd0, 1'b1, 32'hAAAA_5555, 32'h5555_AAAA, PROTO_TCP);
		// protocols next to TCP and UDP do not enable the pseudo-header
		send_item(32'h0001_0002, 3'd5, 1'b1, 32'h1111_2222, 32'h3333_4444, 8'd7);
		send_item(32'h0F0F_F0F0, 3'd6, 1'b1, 32'h1111_2222, 32'h3333_4444, 8'd16);
		send_item(32'h7FFF_0000, 3'd2, 1'b0, 32'h0, 32'h0, 8'd5);
		send_item(32'hFFFF_8001, 3'd4, 1'b1, 32'h0, 32'h0, 8'd0);

		// random packets under each idle/stall mix
		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 48; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 48; end
				default: begin gap_pct = 23; stall_pct = 23; end
			endcase
			sent = 0;
			while (sent < 135) begin
				run_random_packet(n);
				sent += n;
			end
		end

		in_valid <= 1'b0;

		// drain, then keep watching for stray checksums
		drain = 0;
		while (sb.cksum_q.size() != 0 && drain < 10000) begin
			@(posedge clk);
			drain++;
		end
		repeat (8) @(posedge clk);
		if (sb.cksum_q.size() != 0)
			sb.flag_mismatch($sformatf("%0d checksums never arrived", sb.cksum_q.size()));

		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
sv/tuic_pkg.sv
sv/tuic_lane.sv
sv/tuic_merge.sv
sv/tcp_udp_internet_checksum.sv
dv/tb_tcp_udp_internet_checksum.sv
